// ===== src/radar_frame_deframer_assert.svh =====
// assertion macros for the radar frame deframer checker
// needs clk and rst_n in the scope where the macros are used
`ifndef RADAR_FRAME_DEFRAMER_ASSERT_SVH
`define RADAR_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define RFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfd check failed");

// next-cycle implication, ignored while reset is held
`define RFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfd check failed");

// next-cycle implication that also holds across reset
`define RFD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rfd reset check failed");

`endif

// ===== src/rfd_pkg.sv =====
// shared types and constants for the radar frame deframer
// no dependencies
package rfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int KIND_W  = 3;
  localparam int LIMIT_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [63:0] MAGIC_WORD = 64'h0201040306050807;

  localparam logic [WORD_W-1:0] FRAME_START_OFS = 32'd8;
  localparam logic [WORD_W-1:0] HEADER_END_OFS  = 32'd40;
  localparam logic [WORD_W-1:0] TLV_TYPE_OFS    = 32'd43;
  localparam logic [WORD_W-1:0] TLV_END_OFS     = 32'd48;
  localparam logic [WORD_W-1:0] PAYLOAD_OFS     = 32'd51;
  localparam logic [WORD_W-1:0] LEN_LAST_OFS    = 32'd15;

  localparam logic [WORD_W-1:0] PTC_RESET   = 32'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;

  // record kinds
  localparam logic [KIND_W-1:0] KIND_HDR_LO = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HDR_HI = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TLV    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POINT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PTC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

  // result queue
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = 3;
  localparam int Q_CNT_W = 4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;
    logic              last;
  } rfd_rec_t;

  // records produced by one byte, rec0 goes out first
  typedef struct packed {
    logic [1:0] cnt;
    rfd_rec_t   rec0;
    rfd_rec_t   rec1;
  } rfd_push_t;

endpackage

// ===== src/rfd_in_if.sv =====
// byte input channel of the radar frame deframer
// depends on rfd_pkg
interface rfd_in_if import rfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== src/rfd_out_if.sv =====
// record output channel of the radar frame deframer
// depends on rfd_pkg
interface rfd_out_if import rfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] record_kind;
  logic [WORD_W-1:0] word0;
  logic [WORD_W-1:0] word1;
  logic [WORD_W-1:0] word2;
  logic [WORD_W-1:0] word3;
  logic              last_of_run;

  modport source (output valid, output record_kind, output word0, output word1,
                  output word2, output word3, output last_of_run, input ready);
  modport sink (input valid, input record_kind, input word0, input word1,
                input word2, input word3, input last_of_run, output ready);
endinterface

// ===== src/rfd_parser.sv =====
// frame parser: magic search, header and tlv word assembly, point records
// depends on rfd_pkg; one registered byte in, up to two records out per byte
module rfd_parser import rfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_valid,
  input  logic [BYTE_W-1:0]  byte_data,
  input  logic [WORD_W-1:0]  points_type_code,
  input  logic [LIMIT_W-1:0] point_limit,
  output rfd_push_t          push
);

  logic [63:0]        window_r, window_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic [WORD_W-1:0]  offset_r, offset_nxt;
  logic [WORD_W-1:0]  flen_r, flen_nxt;
  logic [WORD_W-1:0]  wbuf_r, wbuf_nxt;
  logic [WORD_W-1:0]  hdr_r [3];
  logic [WORD_W-1:0]  hdr_nxt [3];
  logic [WORD_W-1:0]  tlv_type_r, tlv_type_nxt;
  logic [WORD_W-1:0]  tlv_len_r, tlv_len_nxt;
  logic [WORD_W-1:0]  pw_r [3];
  logic [WORD_W-1:0]  pw_nxt [3];
  logic [LIMIT_W-1:0] pe_r, pe_nxt;

  always_comb begin
    logic [WORD_W-1:0] o;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] flen_eff;
    logic              has_rec;
    logic              frame_end;
    rfd_rec_t          rec;
    rfd_rec_t          end_rec;

    window_nxt   = window_r;
    in_frame_nxt = in_frame_r;
    offset_nxt   = offset_r;
    flen_nxt     = flen_r;
    wbuf_nxt     = wbuf_r;
    hdr_nxt      = hdr_r;
    tlv_type_nxt = tlv_type_r;
    tlv_len_nxt  = tlv_len_r;
    pw_nxt       = pw_r;
    pe_nxt       = pe_r;
    push         = '0;

    o         = offset_r;
    w         = {byte_data, wbuf_r[WORD_W-1:BYTE_W]};
    flen_eff  = flen_r;
    has_rec   = 1'b0;
    frame_end = 1'b0;
    rec       = '0;
    end_rec   = '0;

    if (byte_valid) begin
      if (!in_frame_r) begin
        window_nxt = {window_r[63-BYTE_W:0], byte_data};
        if (window_nxt == MAGIC_WORD) begin
          in_frame_nxt = 1'b1;
          offset_nxt   = FRAME_START_OFS;
          flen_nxt     = '0;
          wbuf_nxt     = '0;
          pe_nxt       = '0;
        end
      end else begin
        wbuf_nxt = w;
        if (o[1:0] == 2'd3) begin
          if (o < HEADER_END_OFS) begin
            // header word index is o[5:2] - 2
            case (o[5:2])
              4'd2: hdr_nxt[0] = w;
              4'd3: begin
                hdr_nxt[1] = w;
                flen_nxt   = w;
                flen_eff   = w;
              end
              4'd4: hdr_nxt[2] = w;
              4'd5: begin
                has_rec = 1'b1;
                rec = '{kind: KIND_HDR_LO, word0: hdr_r[0], word1: hdr_r[1],
                        word2: hdr_r[2], word3: w, last: 1'b0};
              end
              4'd6: hdr_nxt[0] = w;
              4'd7: hdr_nxt[1] = w;
              4'd8: hdr_nxt[2] = w;
              4'd9: begin
                has_rec = 1'b1;
                rec = '{kind: KIND_HDR_HI, word0: hdr_r[0], word1: hdr_r[1],
                        word2: hdr_r[2], word3: w, last: 1'b0};
              end
              default: ;
            endcase
          end else if (o < TLV_END_OFS) begin
            if (o == TLV_TYPE_OFS) begin
              tlv_type_nxt = w;
            end else begin
              tlv_len_nxt = w;
              has_rec = 1'b1;
              rec = '{kind: KIND_TLV, word0: tlv_type_r, word1: w,
                      word2: '0, word3: '0, last: 1'b0};
            end
          end else if (tlv_type_r == points_type_code &&
                       (o - PAYLOAD_OFS) < tlv_len_r) begin
            // payload offset is a multiple of 16 from the frame, so o[3:2] picks the word
            if (o[3:2] != 2'd3) begin
              pw_nxt[o[3:2]] = w;
            end else if (pe_r < point_limit) begin
              has_rec = 1'b1;
              rec = '{kind: KIND_POINT, word0: pw_r[0], word1: pw_r[1],
                      word2: pw_r[2], word3: w, last: 1'b0};
              pe_nxt = pe_r + LIMIT_W'(1);
            end
          end
        end

        frame_end = (o >= LEN_LAST_OFS) &&
                    (({1'b0, o} + 33'd1) >= {1'b0, flen_eff});
        if (frame_end) begin
          in_frame_nxt = 1'b0;
          window_nxt   = '0;
          offset_nxt   = '0;
        end else begin
          offset_nxt = o + 32'd1;
        end

        end_rec = '{kind: KIND_END, word0: {{(WORD_W-LIMIT_W){1'b0}}, pe_nxt},
                    word1: '0, word2: '0, word3: '0, last: 1'b1};
        if (has_rec && frame_end) begin
          push.cnt  = 2'd2;
          push.rec0 = rec;
          push.rec1 = end_rec;
        end else if (frame_end) begin
          push.cnt  = 2'd1;
          push.rec0 = end_rec;
        end else if (has_rec) begin
          push.cnt       = 2'd1;
          push.rec0      = rec;
          push.rec0.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '0;
      in_frame_r <= 1'b0;
      offset_r   <= '0;
      flen_r     <= '0;
      wbuf_r     <= '0;
      hdr_r      <= '{default: '0};
      tlv_type_r <= '0;
      tlv_len_r  <= '0;
      pw_r       <= '{default: '0};
      pe_r       <= '0;
    end else begin
      window_r   <= window_nxt;
      in_frame_r <= in_frame_nxt;
      offset_r   <= offset_nxt;
      flen_r     <= flen_nxt;
      wbuf_r     <= wbuf_nxt;
      hdr_r      <= hdr_nxt;
      tlv_type_r <= tlv_type_nxt;
      tlv_len_r  <= tlv_len_nxt;
      pw_r       <= pw_nxt;
      pe_r       <= pe_nxt;
    end
  end

endmodule

// ===== src/rfd_queue.sv =====
// result queue: takes up to two records a cycle, hands out one
// depends on rfd_pkg
module rfd_queue import rfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rfd_push_t          push,
  input  logic               pop,
  output rfd_rec_t           head,
  output logic               head_valid,
  output logic [Q_CNT_W-1:0] count
);

  rfd_rec_t           mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + Q_PTR_W'(1);
  assign head       = mem[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.rec0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.rec1;
    end
  end

endmodule

// ===== src/radar_frame_deframer.sv =====
// radar frame deframer top level: byte input register, parser, result queue
// a byte is registered on transfer, then its records are written into the queue
// throughput: one byte per cycle; a byte may make two records, which drain
//   one per cycle when out_ch is ready; an 8-entry queue throttles input near full
// reset: rst_n synchronous active low; searching for magic, type code 1, limit 100
// depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_parser, rfd_queue
module radar_frame_deframer import rfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rfd_in_if.sink               in_ch,
  rfd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic [WORD_W-1:0]  ptc_r;
  logic [LIMIT_W-1:0] limit_r;
  rfd_push_t          push;
  rfd_rec_t           head;
  logic               head_valid;
  logic [Q_CNT_W-1:0] q_count;
  logic               in_xfer;
  logic               out_xfer;
  logic [Q_CNT_W:0]   q_claim;

  // room for the byte in flight plus the new one, two records each
  assign q_claim     = {1'b0, q_count} + (s1_valid_r ? (Q_CNT_W+1)'(2) : '0);
  assign in_ch.ready = (q_claim <= (Q_CNT_W+1)'(Q_DEPTH - 2));
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptc_r   <= PTC_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PTC) begin
        ptc_r <= cfg_data;
      end else if (cfg_index == CFG_LIMIT) begin
        limit_r <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  rfd_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_valid       (s1_valid_r),
    .byte_data        (s1_byte_r),
    .points_type_code (ptc_r),
    .point_limit      (limit_r),
    .push             (push)
  );

  rfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_xfer),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  assign out_ch.valid       = head_valid;
  assign out_ch.record_kind = head.kind;
  assign out_ch.word0       = head.word0;
  assign out_ch.word1       = head.word1;
  assign out_ch.word2       = head.word2;
  assign out_ch.word3       = head.word3;
  assign out_ch.last_of_run = head.last;

endmodule

// ===== src/rfd_checker.sv =====
// port-level checks for the radar frame deframer, bound to the top level
// depends on rfd_pkg and radar_frame_deframer_assert.svh
`include "radar_frame_deframer_assert.svh"

module rfd_checker import rfd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] record_kind,
  input logic [WORD_W-1:0] word1,
  input logic [WORD_W-1:0] word2,
  input logic [WORD_W-1:0] word3,
  input logic              last_of_run
);

  // a pending record is not withdrawn
  `RFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // the frame end record closes the run and carries only the count
  `RFD_ASSERT_NOW(a_end_shape, out_valid && record_kind == KIND_END, last_of_run && word1 == '0 && word2 == '0 && word3 == '0)
  // tlv records have zero upper words
  `RFD_ASSERT_NOW(a_tlv_shape, out_valid && record_kind == KIND_TLV, word2 == '0 && word3 == '0)
  // nothing comes out right after reset
  `RFD_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind radar_frame_deframer rfd_checker u_rfd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .record_kind (out_ch.record_kind),
  .word1       (out_ch.word1),
  .word2       (out_ch.word2),
  .word3       (out_ch.word3),
  .last_of_run (out_ch.last_of_run)
);
